// ===== design/kth_permutation_unrank_assert.svh =====
// ============================================================================
// kth_permutation_unrank_assert.svh
// Assertion macros shared by the permutation unrank modules. Every macro
// samples on the rising edge of clk and is disabled while arst_n is low.
// ============================================================================
`ifndef KTH_PERMUTATION_UNRANK_ASSERT_SVH
`define KTH_PERMUTATION_UNRANK_ASSERT_SVH

// Check that cond holds in the same cycle as trig
`define KPU_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(trig) |-> (cond)) else $error(msg);

// Check that cond holds in the cycle after trig
`define KPU_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(trig) |=> (cond)) else $error(msg);

`endif

// ===== design/kpu_pkg.sv =====
// ============================================================================
// kpu_pkg
// Widths, factorial table and controller/datapath handshake types for the
// permutation unrank block.
// ============================================================================
package kpu_pkg;

	localparam int RANK_W = 19;
	localparam int LEN_W  = 4;
	localparam int ELEM_W = 4;
	localparam int FACT_W = 29;

	localparam logic [LEN_W-1:0] LEN_RESET = 4'd9;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // capture the rank of an accepted item
		logic init;      // set up list, remainder and digit counters
		logic sub;       // one subtract step of the digit division
		logic emit;      // issue one element and close the gap in the list
		logic emit_err;  // issue the single error result
	} kpu_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic err;   // rank or length out of range
		logic ge;    // remainder still at or above the current factorial
		logic last;  // one element left in the list
	} kpu_stat_t;

	// n! for n up to 12; codes above that return all ones
	function automatic logic [FACT_W-1:0] fact(input logic [LEN_W-1:0] n);
		logic [FACT_W-1:0] f;
		case (n)
			4'd0:    f = 29'd1;
			4'd1:    f = 29'd1;
			4'd2:    f = 29'd2;
			4'd3:    f = 29'd6;
			4'd4:    f = 29'd24;
			4'd5:    f = 29'd120;
			4'd6:    f = 29'd720;
			4'd7:    f = 29'd5040;
			4'd8:    f = 29'd40320;
			4'd9:    f = 29'd362880;
			4'd10:   f = 29'd3628800;
			4'd11:   f = 29'd39916800;
			4'd12:   f = 29'd479001600;
			default: f = '1;
		endcase
		return f;
	endfunction

endpackage

// ===== design/kpu_ctrl.sv =====
// ============================================================================
// kpu_ctrl
// Sequencer for the unrank block: takes an item, checks its range, then gives
// an error result, or alternates subtract steps and element emits until the list is used up.
// ============================================================================
module kpu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kpu_pkg::kpu_stat_t stat,
	output kpu_pkg::kpu_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.err) begin
					cmd.emit_err = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.init = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.ge) begin
					cmd.sub = 1'b1;
				end else begin
					cmd.emit = 1'b1;
					if (stat.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`include "kth_permutation_unrank_assert.svh"

	`KPU_ASSERT_NEXT(a_accept_to_check, start && !busy, state_q == ST_CHECK, "item not checked")
	`KPU_ASSERT_NEXT(a_last_to_idle, cmd.emit && stat.last, state_q == ST_IDLE, "no idle after last")
	`KPU_ASSERT_NEXT(a_check_once, state_q == ST_CHECK, state_q != ST_CHECK, "check state held")

endmodule

// ===== design/kpu_dpath.sv =====
// ============================================================================
// kpu_dpath
// Datapath for the unrank block: length register, remainder with a
// subtract-per-cycle divider, list of unused values and result registers.
// ============================================================================
module kpu_dpath #(
	parameter int MAX_LENGTH = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kpu_pkg::kpu_cmd_t            cmd,
	output kpu_pkg::kpu_stat_t           stat,
	input  logic [kpu_pkg::RANK_W-1:0]   rank,
	input  logic                         cfg_we,
	input  logic [kpu_pkg::LEN_W-1:0]    cfg_data,
	output logic                         result_valid,
	output logic [kpu_pkg::LEN_W-1:0]    position,
	output logic [kpu_pkg::ELEM_W-1:0]   element,
	output logic                         last,
	output logic                         error
);

	localparam int SEL_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int PAD_W = kpu_pkg::FACT_W - kpu_pkg::RANK_W;

	logic [kpu_pkg::LEN_W-1:0]  len_q;
	logic [kpu_pkg::RANK_W-1:0] rank_q;
	logic [kpu_pkg::RANK_W-1:0] k_q;
	logic [kpu_pkg::LEN_W-1:0]  rem_q;
	logic [kpu_pkg::LEN_W-1:0]  pos_q;
	logic [SEL_W-1:0]           sel_q;
	logic [kpu_pkg::ELEM_W-1:0] avail_q [MAX_LENGTH];

	logic [kpu_pkg::FACT_W-1:0] len_fact;
	logic [kpu_pkg::FACT_W-1:0] digit_fact;

	logic                        result_valid_q;
	logic [kpu_pkg::LEN_W-1:0]   position_q;
	logic [kpu_pkg::ELEM_W-1:0]  element_q;
	logic                        last_q;
	logic                        error_q;

	// Status toward the controller
	assign len_fact   = kpu_pkg::fact(len_q);
	assign digit_fact = kpu_pkg::fact(rem_q - 4'd1);
	assign stat.err   = (len_q == '0) || (len_q > kpu_pkg::LEN_W'(MAX_LENGTH)) ||
	                    (rank_q == '0) || ({{PAD_W{1'b0}}, rank_q} > len_fact);
	assign stat.ge    = ({{PAD_W{1'b0}}, k_q} >= digit_fact);
	assign stat.last  = (rem_q == 4'd1);

	// Length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= kpu_pkg::LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_data;
		end
	end

	// Rank capture, remainder division and list upkeep
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rank_q <= rank;
		end
		if (cmd.init) begin
			k_q   <= rank_q - 19'd1;
			rem_q <= len_q;
			pos_q <= '0;
			sel_q <= '0;
			for (int i = 0; i < MAX_LENGTH; i++) begin
				avail_q[i] <= kpu_pkg::ELEM_W'(i + 1);
			end
		end
		if (cmd.sub) begin
			k_q   <= k_q - digit_fact[kpu_pkg::RANK_W-1:0];
			sel_q <= sel_q + SEL_W'(1);
		end
		if (cmd.emit) begin
			rem_q <= rem_q - 4'd1;
			pos_q <= pos_q + 4'd1;
			sel_q <= '0;
			// close the gap left by the chosen value
			for (int i = 0; i < MAX_LENGTH - 1; i++) begin
				if (SEL_W'(i) >= sel_q) begin
					avail_q[i] <= avail_q[i + 1];
				end
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit || cmd.emit_err;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			position_q <= pos_q;
			element_q  <= avail_q[sel_q];
			last_q     <= stat.last;
			error_q    <= 1'b0;
		end else if (cmd.emit_err) begin
			position_q <= '0;
			element_q  <= '0;
			last_q     <= 1'b1;
			error_q    <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign position     = position_q;
	assign element      = element_q;
	assign last         = last_q;
	assign error        = error_q;

	`include "kth_permutation_unrank_assert.svh"

	`KPU_ASSERT_SAME(a_sub_no_underflow, cmd.sub, stat.ge, "subtract below zero")
	`KPU_ASSERT_SAME(a_err_shape, result_valid_q && error_q,
		last_q && (element_q == '0) && (position_q == '0), "bad error result")
	`KPU_ASSERT_SAME(a_elem_range, result_valid_q && !error_q,
		(element_q != '0) && (element_q <= len_q), "element out of range")

endmodule

// ===== design/kth_permutation_unrank.sv =====
// ============================================================================
// kth_permutation_unrank
// Decodes a one-based lexicographic rank into the permutation of 1..L,
// L being the configured length, one element per result.
//
// Channel   Signals                                Handshake
// input     start, busy, rank                      start && !busy
// result    result_valid, position, element,       result_valid, one cycle
//           last, error
// config    cfg_valid, cfg_ready, cfg_data         cfg_valid && cfg_ready
//
// An item keeps the block busy for a range check, then per position one
// subtract per unit of the factorial digit and one element emit.
// An out-of-range rank or length is answered with a single error result from the check.
// The digit divider subtracts one factorial per cycle, which sets the rate.
// Reset loads length 9 and idles; results cannot be stalled.
// ============================================================================
module kth_permutation_unrank #(
	parameter int MAX_LENGTH = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [kpu_pkg::RANK_W-1:0]   rank,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [kpu_pkg::LEN_W-1:0]    cfg_data,
	output logic                         result_valid,
	output logic [kpu_pkg::LEN_W-1:0]    position,
	output logic [kpu_pkg::ELEM_W-1:0]   element,
	output logic                         last,
	output logic                         error
);

	kpu_pkg::kpu_cmd_t  cmd;
	kpu_pkg::kpu_stat_t stat;
	logic               cfg_we;

	// Take length writes only while idle
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	kpu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	kpu_dpath #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.rank         (rank),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.position     (position),
		.element      (element),
		.last         (last),
		.error        (error)
	);

endmodule

// ===== verif/kth_permutation_unrank_tb.sv =====
// ============================================================================
// kth_permutation_unrank_tb
// Self-checking bench for the permutation unrank block. Ranks are driven
// over the start/busy command port and each accepted item is decoded by a
// behavioral predictor into the expected element sequence. Results are
// compared field by field in order. The run covers boundary ranks, every
// valid length setting and several invalid ones, and random ranks under several
// sender idle rates.
// ============================================================================
module kth_permutation_unrank_tb;

	localparam int MAX_LEN     = 9;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEG_ITEMS   = 34;

	typedef struct {
		logic [kpu_pkg::LEN_W-1:0]  position;
		logic [kpu_pkg::ELEM_W-1:0] element;
		logic                       last;
		logic                       error;
	} perm_elem_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [kpu_pkg::RANK_W-1:0]  rank;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [kpu_pkg::LEN_W-1:0]   cfg_data;
	logic                        result_valid;
	logic [kpu_pkg::LEN_W-1:0]   position;
	logic [kpu_pkg::ELEM_W-1:0]  element;
	logic                        last;
	logic                        error;

	perm_elem_t                  expected_elems[$];
	logic [kpu_pkg::LEN_W-1:0]   model_len;
	int unsigned                 sender_idle_pct;
	int unsigned                 fail_count;
	int unsigned                 cycle_count;

	kth_permutation_unrank #(
		.MAX_LENGTH(MAX_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.rank(rank),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.position(position),
		.element(element),
		.last(last),
		.error(error)
	);

	// Free-running clock, period 10
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("kth_permutation_unrank test failed");
			$finish;
		end
	end

	function automatic int unsigned fact_of(input int unsigned n);
		int unsigned f;
		f = 1;
		for (int unsigned i = 2; i <= n; i++)
			f *= i;
		return f;
	endfunction

	// Decode one rank at the current length and queue the expected elements
	function automatic void unrank_expect(input logic [kpu_pkg::RANK_W-1:0] r);
		int unsigned pool [MAX_LEN];
		int unsigned len;
		int unsigned k;
		int unsigned f;
		int unsigned sel;
		int unsigned rem;
		perm_elem_t  e;
		len = model_len;
		if (len == 0 || len > MAX_LEN || r == 0 || r > fact_of(len)) begin
			e.position = '0;
			e.element  = '0;
			e.last     = 1'b1;
			e.error    = 1'b1;
			expected_elems = {expected_elems, e};
			return;
		end
		for (int unsigned i = 0; i < len; i++)
			pool[i] = i + 1;
		k = r - 1;
		for (int unsigned p = 0; p < len; p++) begin
			rem = len - p;
			f = fact_of(rem - 1);
			sel = k / f;
			e.position = kpu_pkg::LEN_W'(p);
			e.element  = kpu_pkg::ELEM_W'(pool[sel]);
			e.last     = (rem == 1);
			e.error    = 1'b0;
			expected_elems = {expected_elems, e};
			// close the gap left by the picked value
			for (int unsigned i = sel; i + 1 < rem; i++)
				pool[i] = pool[i + 1];
			k = k % f;
		end
	endfunction

	// Compare each result with the oldest expected element
	always @(posedge clk) begin
		perm_elem_t want;
		if (arst_n && result_valid) begin
			if (expected_elems.size() == 0) begin
				$error("unexpected result: position %0d element %0d last %0b error %0b",
					position, element, last, error);
				fail_count++;
			end else begin
				want = expected_elems.pop_front();
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					fail_count++;
				end
				if (element !== want.element) begin
					$error("element: expected %0d, actual %0d", want.element, element);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, last);
					fail_count++;
				end
				if (error !== want.error) begin
					$error("error: expected %0b, actual %0b", want.error, error);
					fail_count++;
				end
			end
		end
	end

	// Offer one rank, with a random idle gap first, and hold until accepted
	task automatic send_rank(input logic [kpu_pkg::RANK_W-1:0] r);
		@(negedge clk);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < sender_idle_pct)
				@(negedge clk);
		end
		start = 1'b1;
		rank  = r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		unrank_expect(r);
	endtask

	// Drop start and wait until every expected result is back and the block idles
	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (expected_elems.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Write the length register; call only while idle
	task automatic write_perm_length(input logic [kpu_pkg::LEN_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		model_len = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly in-range ranks, some at the edges, some of any 19-bit value
	function automatic logic [kpu_pkg::RANK_W-1:0] pick_rank();
		int unsigned top;
		int unsigned roll;
		top = (model_len >= 1 && model_len <= MAX_LEN) ? fact_of(model_len) : 362880;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return kpu_pkg::RANK_W'($urandom_range(1, top));
		if (roll < 88) begin
			case ($urandom_range(0, 3))
				0:       return kpu_pkg::RANK_W'(1);
				1:       return kpu_pkg::RANK_W'(top);
				2:       return kpu_pkg::RANK_W'(top + 1);
				default: return '0;
			endcase
		end
		return kpu_pkg::RANK_W'($urandom());
	endfunction

	// Boundary ranks at the reset length
	task automatic test_reset_length;
		sender_idle_pct = 0;
		send_rank(19'd1);
		send_rank(19'd362880);
		send_rank(19'd2);
		send_rank(19'h2AAAA);
		send_rank(19'h55555);
		send_rank(19'd0);
		send_rank(19'd362881);
		send_rank(19'h7FFFF);
		drain();
	endtask

	// Smallest, largest and invalid lengths
	task automatic test_length_extremes;
		write_perm_length(4'd1);
		send_rank(19'd1);
		send_rank(19'd2);
		drain();
		write_perm_length(4'd2);
		send_rank(19'd1);
		send_rank(19'd2);
		send_rank(19'd3);
		drain();
		write_perm_length(4'd8);
		send_rank(19'd40320);
		send_rank(19'd40321);
		drain();
		write_perm_length(4'd0);
		send_rank(19'd1);
		drain();
		write_perm_length(4'd15);
		send_rank(19'd6);
		drain();
		write_perm_length(4'd10);
		send_rank(19'd1);
		drain();
		write_perm_length(4'd9);
		send_rank(19'd1);
		send_rank(19'd362880);
		drain();
	endtask

	// Random ranks over many lengths and sender idle rates
	task automatic test_random_ranks;
		logic [kpu_pkg::LEN_W-1:0] lens [12];
		int unsigned               pcts [3];
		lens = '{4'd9, 4'd2, 4'd6, 4'd1, 4'd8, 4'd3, 4'd7, 4'd0, 4'd5, 4'd4, 4'd13, 4'd9};
		pcts = '{0, 77, 21};
		for (int seg = 0; seg < 12; seg++) begin
			drain();
			write_perm_length(lens[seg]);
			sender_idle_pct = pcts[seg % 3];
			for (int n = 0; n < SEG_ITEMS; n++) begin
				// hold off mid-stream until every result is back
				if (seg == 4 && n == SEG_ITEMS / 2)
					drain();
				send_rank(pick_rank());
			end
		end
		drain();
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		rank            = '0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		model_len       = kpu_pkg::LEN_RESET;
		sender_idle_pct = 0;
		fail_count      = 0;
		cycle_count     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_length();
		test_length_extremes();
		test_random_ranks();

		// let any stray result show up
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("kth_permutation_unrank test passed");
		else
			$display("kth_permutation_unrank test failed");
		$finish;
	end

endmodule
